// File: rtl/arp_pkg.sv
// Shared types, codes and a helper function for the ARM relocation patcher.
package arp_pkg;

   localparam int WORD_W = 32;
   localparam int CMD_W = 5;
   localparam int CSR_INDEX_W = 3;
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   // relocation kinds on req_command
   localparam logic [CMD_W-1:0] CMD_PC24 = 5'd0;
   localparam logic [CMD_W-1:0] CMD_CALL = 5'd1;
   localparam logic [CMD_W-1:0] CMD_JUMP24 = 5'd2;
   localparam logic [CMD_W-1:0] CMD_PLT32 = 5'd3;
   localparam logic [CMD_W-1:0] CMD_THM_PC22 = 5'd4;
   localparam logic [CMD_W-1:0] CMD_THM_JUMP24 = 5'd5;
   localparam logic [CMD_W-1:0] CMD_MOVW_ABS_NC = 5'd6;
   localparam logic [CMD_W-1:0] CMD_MOVT_ABS = 5'd7;
   localparam logic [CMD_W-1:0] CMD_MOVW_PREL_NC = 5'd8;
   localparam logic [CMD_W-1:0] CMD_MOVT_PREL = 5'd9;
   localparam logic [CMD_W-1:0] CMD_THM_MOVW_ABS_NC = 5'd10;
   localparam logic [CMD_W-1:0] CMD_THM_MOVT_ABS = 5'd11;
   localparam logic [CMD_W-1:0] CMD_PREL31 = 5'd12;
   localparam logic [CMD_W-1:0] CMD_ABS32 = 5'd13;
   localparam logic [CMD_W-1:0] CMD_REL32 = 5'd14;
   localparam logic [CMD_W-1:0] CMD_GOTPC = 5'd15;
   localparam logic [CMD_W-1:0] CMD_GOTOFF = 5'd16;
   localparam logic [CMD_W-1:0] CMD_GOT32 = 5'd17;
   localparam logic [CMD_W-1:0] CMD_GOT_PREL = 5'd18;
   localparam logic [CMD_W-1:0] CMD_V4BX = 5'd19;
   localparam logic [CMD_W-1:0] CMD_GLOB_DAT = 5'd20;
   localparam logic [CMD_W-1:0] CMD_TLS_LE32 = 5'd21;
   localparam logic [CMD_W-1:0] CMD_NONE = 5'd22;

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_BLX_AVAILABLE = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GOT_BASE = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PLT_BASE = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PLT_SIZE = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_TLS_BASE = 3'd4;

   localparam logic [7:0] ARM_BL_CODE = 8'heb;
   localparam logic [7:0] ARM_BLX_CODE = 8'hfa;
   localparam logic [WORD_W-1:0] BX_MASK = 32'h0ffffff0;
   localparam logic [WORD_W-1:0] BX_PATTERN = 32'h012fff10;
   localparam logic [WORD_W-1:0] BX_WORD = 32'he12fff10;
   localparam logic [WORD_W-1:0] MOV_PC_WORD = 32'he1a0f000;
   localparam logic [WORD_W-1:0] MOVW_KEEP_MASK = 32'hfff0f000;
   localparam logic [WORD_W-1:0] TLS_TCB_SIZE = 32'd8;

   typedef enum logic [1:0] {
      ST_OK = 2'd0,
      ST_BAD = 2'd1,
      ST_UNHANDLED = 2'd2,
      ST_STUB = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      OP_ARM_BRANCH,
      OP_THUMB_BRANCH,
      OP_MOV_PREL,
      OP_PREL31,
      OP_ADD,
      OP_OR,
      OP_STORE,
      OP_UNHANDLED
   } op_type;

   typedef struct packed {
      logic             blx_available;
      logic [WORD_W-1:0] got_base;
      logic [WORD_W-1:0] plt_base;
      logic [WORD_W-1:0] plt_size;
      logic [WORD_W-1:0] tls_base;
   } cfg_type;

   // classified request, as handed from front to back
   typedef struct packed {
      op_type           op;
      logic [WORD_W-1:0] word;
      logic [WORD_W-1:0] symbol;
      logic [WORD_W-1:0] diff;
      logic [WORD_W-1:0] diff3;
      logic [WORD_W-1:0] operand;
      logic             arm_call;
      logic             thumb_call;
      logic             top_half;
      logic             to_plt;
      logic             weak_undef;
      logic             blx_ok;
   } item_type;

   // scatter a 16-bit immediate into the Thumb MOVW/MOVT pair layout
   function automatic logic [WORD_W-1:0] thumb_mov_imm(input logic [15:0] v);
      logic [WORD_W-1:0] r;
      r = '0;
      r[30:28] = v[10:8];
      r[23:16] = v[7:0];
      r[10] = v[11];
      r[3:0] = v[15:12];
      return r;
   endfunction

endpackage

// File: rtl/arp_front.sv
// Front stage: accepts a relocation request, classifies it and computes its operands.
module arp_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [arp_pkg::CMD_W-1:0]  req_command,
   input  logic [arp_pkg::WORD_W-1:0] req_original_word,
   input  logic [arp_pkg::WORD_W-1:0] req_place_address,
   input  logic [arp_pkg::WORD_W-1:0] req_symbol_value,
   input  logic [arp_pkg::WORD_W-1:0] req_got_entry_offset,
   input  logic                       req_weak_undefined,
   input  arp_pkg::cfg_type           cfg,
   input  logic                       queue_full,
   output logic                       push,
   output arp_pkg::item_type          item
);
   import arp_pkg::*;

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   logic     accept;

   assign busy = valid_ff & queue_full;
   assign accept = start & ~busy;
   assign push = valid_ff & ~queue_full;
   assign item = item_ff;

   always_comb begin
      logic [WORD_W-1:0] w, pa, sv;
      logic [15:0]       half;
      logic [WORD_W:0]   plt_end;
      w = req_original_word;
      pa = req_place_address;
      sv = req_symbol_value;
      plt_end = {1'b0, cfg.plt_base} + {1'b0, cfg.plt_size};
      half = (req_command == CMD_MOVT_ABS || req_command == CMD_THM_MOVT_ABS) ?
             sv[31:16] : sv[15:0];

      item_in.op = OP_ADD;
      item_in.word = w;
      item_in.symbol = sv;
      item_in.diff = sv - pa;
      item_in.diff3 = sv - pa + 32'd3;
      item_in.operand = '0;
      item_in.arm_call = (req_command == CMD_CALL) ||
                         (req_command == CMD_PC24 && w[31:24] == ARM_BL_CODE);
      item_in.thumb_call = (req_command == CMD_THM_PC22);
      item_in.top_half = (req_command == CMD_MOVT_PREL);
      item_in.to_plt = ({1'b0, sv} >= {1'b0, cfg.plt_base}) && ({1'b0, sv} < plt_end);
      item_in.weak_undef = req_weak_undefined;
      item_in.blx_ok = cfg.blx_available;

      unique case (req_command)
         CMD_PC24, CMD_CALL, CMD_JUMP24, CMD_PLT32: item_in.op = OP_ARM_BRANCH;
         CMD_THM_PC22, CMD_THM_JUMP24: item_in.op = OP_THUMB_BRANCH;
         CMD_MOVW_ABS_NC, CMD_MOVT_ABS: begin
            item_in.operand = {12'd0, half[15:12], 4'd0, half[11:0]};
         end
         CMD_MOVW_PREL_NC, CMD_MOVT_PREL: item_in.op = OP_MOV_PREL;
         CMD_THM_MOVW_ABS_NC: item_in.operand = thumb_mov_imm(half);
         CMD_THM_MOVT_ABS: begin
            item_in.op = OP_OR;
            item_in.operand = thumb_mov_imm(half);
         end
         CMD_PREL31: item_in.op = OP_PREL31;
         CMD_ABS32: item_in.operand = sv;
         CMD_REL32: item_in.operand = sv - pa;
         CMD_GOTPC: item_in.operand = cfg.got_base - pa;
         CMD_GOTOFF: item_in.operand = sv - cfg.got_base;
         CMD_GOT32: item_in.operand = req_got_entry_offset;
         CMD_GOT_PREL: item_in.operand = cfg.got_base + req_got_entry_offset - pa;
         CMD_V4BX: begin
            item_in.op = OP_STORE;
            item_in.operand = ((w & BX_MASK) == BX_PATTERN) ?
                              (w ^ BX_WORD ^ MOV_PC_WORD) : w;
         end
         CMD_GLOB_DAT: begin
            item_in.op = OP_STORE;
            item_in.operand = sv;
         end
         CMD_TLS_LE32: item_in.operand = sv - cfg.tls_base + TLS_TCB_SIZE;
         CMD_NONE: begin
            item_in.op = OP_STORE;
            item_in.operand = w;
         end
         default: item_in.op = OP_UNHANDLED;
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (push) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

endmodule

// File: rtl/arp_queue.sv
// Short queue of classified requests between the front and back stages.
module arp_queue #(
   parameter int DEPTH = arp_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  arp_pkg::item_type push_item,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output arp_pkg::item_type head_item
);
   import arp_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   item_type         entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full = (count_ff == FULL_CNT);
   assign head_valid = (count_ff != '0);
   assign head_item = entry_ff[rd_ptr_ff];
   assign do_push = push & ~full;
   assign do_pop = pop & head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// File: rtl/arp_back.sv
// Back stage: applies the classified relocation and registers the result beat.
module arp_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       head_valid,
   input  arp_pkg::item_type          head_item,
   output logic                       pop,
   output logic                       rsp_strobe,
   output logic [arp_pkg::WORD_W-1:0] rsp_patched_word,
   output logic [1:0]                 rsp_status
);
   import arp_pkg::*;

   logic              strobe_ff;
   logic [WORD_W-1:0] word_ff, word_in;
   status_type        status_ff, status_in;

   // the receiver never stalls, so drain one entry every cycle
   assign pop = head_valid;
   assign rsp_strobe = strobe_ff;
   assign rsp_patched_word = word_ff;
   assign rsp_status = status_ff;

   always_comb begin
      item_type          it;
      logic [WORD_W-1:0] w, x, addend, v;
      logic [15:0]       hi, lo, new_hi, new_lo;
      logic              s, i1, i2, s2, j1, j2, h, thumb_target, out_range, th_ko;
      logic              blx_bit;
      logic [24:0]       tx;
      logic [7:0]        code;
      it = head_item;
      w = it.word;
      thumb_target = it.symbol[0];
      word_in = w;
      status_in = ST_OK;
      x = '0;
      hi = w[15:0];
      lo = w[31:16];
      s = hi[10];
      i1 = ~(lo[13] ^ s);
      i2 = ~(lo[11] ^ s);
      tx = {s, i1, i2, hi[9:0], lo[10:0], 1'b0};
      addend = '0;
      v = '0;
      new_hi = '0;
      new_lo = '0;
      s2 = 1'b0;
      j1 = 1'b0;
      j2 = 1'b0;
      h = 1'b0;
      out_range = 1'b0;
      th_ko = 1'b0;
      blx_bit = 1'b1;
      code = w[31:24];

      unique case (it.op)
         OP_ARM_BRANCH: begin
            x = {{6{w[23]}}, w[23:0], 2'b00} + it.diff;
            h = x[1];
            th_ko = (x[1:0] != 2'b00) && (!it.blx_ok || !it.arm_call);
            out_range = (x[31:25] != {7{x[25]}});
            if (th_ko || out_range) begin
               status_in = ST_BAD;
            end
            if (thumb_target) begin
               code = ARM_BLX_CODE | {7'd0, h};
            end
            word_in = {code, x[25:2]};
         end
         OP_THUMB_BRANCH: begin
            if (it.weak_undef) begin
               word_in = w;
            end else if (!thumb_target && !it.to_plt && !it.thumb_call) begin
               status_in = ST_STUB;
            end else begin
               // BL to ARM code becomes BLX: round to a word boundary
               if (!thumb_target && it.thumb_call) begin
                  x = ({{7{tx[24]}}, tx} + it.diff3) & ~32'd3;
                  blx_bit = 1'b0;
               end else begin
                  x = {{7{tx[24]}}, tx} + it.diff;
               end
               out_range = (x[31:24] != {8{x[24]}});
               if ((!thumb_target || out_range) &&
                   (thumb_target || it.symbol[1] || (!it.thumb_call && !it.to_plt))) begin
                  status_in = ST_BAD;
               end
               s2 = x[24];
               j1 = s2 ^ ~x[23];
               j2 = s2 ^ ~x[22];
               new_hi = {hi[15:11], s2, x[21:12]};
               new_lo = {lo[15:14], j1, blx_bit, j2, x[11:1]};
               word_in = {new_lo, new_hi};
            end
         end
         OP_MOV_PREL: begin
            addend = {{16{w[19]}}, w[19:16], w[11:0]};
            v = it.diff + addend;
            if (it.top_half) begin
               v = {16'd0, v[31:16]};
            end
            word_in = (w & MOVW_KEEP_MASK) | {12'd0, v[15:12], 4'd0, v[11:0]};
         end
         OP_PREL31: begin
            x = {w[30], w[30:0]} + it.diff;
            if (x[31] ^ x[30]) begin
               status_in = ST_BAD;
            end
            word_in = {w[31], x[30:0]};
         end
         OP_ADD: word_in = w + it.operand;
         OP_OR: word_in = w | it.operand;
         OP_STORE: word_in = it.operand;
         OP_UNHANDLED: status_in = ST_UNHANDLED;
         default: status_in = ST_UNHANDLED;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= head_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (head_valid) begin
         word_ff <= word_in;
         status_ff <= status_in;
      end
   end

endmodule

// File: rtl/arm_relocation_patcher_core.sv
// Top level of the ARM relocation patcher: configuration registers and stage wiring.
//
// Applies one ARM/Thumb relocation per request. A request is taken on a clock edge with
// start high and busy low; its patched word and status come back on rsp_* with
// rsp_strobe high for one cycle. On its way the request is held in the front register
// and a queue slot, and its result in the output register. The back stage retires one
// queue entry every cycle and the result port cannot stall, so with QUEUE_DEPTH of two
// or more the queue never fills and busy stays low: a new request may be given in every
// cycle, and results leave in request order. Configuration is to be written through
// csr_* only while no request is in flight; the block itself does not enforce this.
module arm_relocation_patcher_core #(
   parameter int QUEUE_DEPTH = arp_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [arp_pkg::CMD_W-1:0]       req_command,
   input  logic [arp_pkg::WORD_W-1:0]      req_original_word,
   input  logic [arp_pkg::WORD_W-1:0]      req_place_address,
   input  logic [arp_pkg::WORD_W-1:0]      req_symbol_value,
   input  logic [arp_pkg::WORD_W-1:0]      req_got_entry_offset,
   input  logic                            req_weak_undefined,
   output logic                            rsp_strobe,
   output logic [arp_pkg::WORD_W-1:0]      rsp_patched_word,
   output logic [1:0]                      rsp_status,
   input  logic                            csr_write_enable,
   input  logic [arp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [arp_pkg::WORD_W-1:0]      csr_write_data
);
   import arp_pkg::*;

   cfg_type  cfg_ff, cfg_in;
   item_type front_item, head_item;
   logic     push, queue_full, head_valid, pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_BLX_AVAILABLE: cfg_in.blx_available = csr_write_data[0];
            CSR_GOT_BASE: cfg_in.got_base = csr_write_data;
            CSR_PLT_BASE: cfg_in.plt_base = csr_write_data;
            CSR_PLT_SIZE: cfg_in.plt_size = csr_write_data;
            CSR_TLS_BASE: cfg_in.tls_base = csr_write_data;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.blx_available <= 1'b1;
         cfg_ff.got_base <= '0;
         cfg_ff.plt_base <= '0;
         cfg_ff.plt_size <= '0;
         cfg_ff.tls_base <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   arp_front u_front (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_command          (req_command),
      .req_original_word    (req_original_word),
      .req_place_address    (req_place_address),
      .req_symbol_value     (req_symbol_value),
      .req_got_entry_offset (req_got_entry_offset),
      .req_weak_undefined   (req_weak_undefined),
      .cfg                  (cfg_ff),
      .queue_full           (queue_full),
      .push                 (push),
      .item                 (front_item)
   );

   arp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (front_item),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   arp_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_valid       (head_valid),
      .head_item        (head_item),
      .pop              (pop),
      .rsp_strobe       (rsp_strobe),
      .rsp_patched_word (rsp_patched_word),
      .rsp_status       (rsp_status)
   );

endmodule

// File: verif/arm_relocation_patcher_core_test.sv
// Self-checking testbench for the ARM relocation patcher core.
module arm_relocation_patcher_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   import arp_pkg::*;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int RANDOM_PHASE_ITEMS = 190;
   localparam logic [7:0] ARM_B_ALWAYS = 8'hea;
   localparam logic [23:0] ARM_PC_ADDEND = 24'hfffffe;
   localparam logic [31:0] THM_BL_PAIR = 32'hf800f000;
   localparam logic [31:0] THM_BW_PAIR = 32'hb800f000;

   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [WORD_W-1:0] original_word;
      logic [WORD_W-1:0] place_address;
      logic [WORD_W-1:0] symbol_value;
      logic [WORD_W-1:0] got_entry_offset;
      logic              weak_undefined;
   } reloc_request_type;

   typedef struct packed {
      logic [WORD_W-1:0] patched_word;
      status_type        status;
   } patch_result_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   logic [CMD_W-1:0]       req_command = '0;
   logic [WORD_W-1:0]      req_original_word = '0;
   logic [WORD_W-1:0]      req_place_address = '0;
   logic [WORD_W-1:0]      req_symbol_value = '0;
   logic [WORD_W-1:0]      req_got_entry_offset = '0;
   logic                   req_weak_undefined = 1'b0;
   logic                   rsp_strobe;
   logic [WORD_W-1:0]      rsp_patched_word;
   logic [1:0]             rsp_status;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [WORD_W-1:0]      csr_write_data = '0;

   cfg_type          patcher_cfg;
   patch_result_type pending_patches[$];
   int               failures = 0;
   int               requests_sent = 0;
   int               settings_applied = 0;
   int               status_counts[4] = '{0, 0, 0, 0};
   int               gap_odds = 0;
   int               idle_cycles = 0;

   arm_relocation_patcher_core dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_command(req_command),
      .req_original_word(req_original_word),
      .req_place_address(req_place_address),
      .req_symbol_value(req_symbol_value),
      .req_got_entry_offset(req_got_entry_offset),
      .req_weak_undefined(req_weak_undefined),
      .rsp_strobe(rsp_strobe),
      .rsp_patched_word(rsp_patched_word),
      .rsp_status(rsp_status),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------- predictor

   function automatic logic [31:0] scatter_thumb_imm(input logic [15:0] v);
      return {1'b0, v[10:8], 4'h0, v[7:0], 5'h00, v[11], 6'h00, v[15:12]};
   endfunction

   function automatic logic [31:0] movw_field(input logic [15:0] v);
      return {12'h000, v[15:12], 4'h0, v[11:0]};
   endfunction

   function automatic patch_result_type patch_arm_branch(input reloc_request_type rq,
                                                         input cfg_type cfg);
      patch_result_type res;
      logic [31:0]      offs;
      logic             call_form;
      logic             misaligned;
      logic             out_of_range;
      offs = {{6{rq.original_word[23]}}, rq.original_word[23:0], 2'b00}
             + rq.symbol_value - rq.place_address;
      call_form = rq.command == CMD_CALL ||
                  (rq.command == CMD_PC24 && rq.original_word[31:24] == ARM_BL_CODE);
      misaligned = offs[1:0] != 2'b00 && (!cfg.blx_available || !call_form);
      out_of_range = !(offs[31:25] == 7'h00 || offs[31:25] == 7'h7f);
      res.status = (misaligned || out_of_range) ? ST_BAD : ST_OK;
      // a Thumb target turns the branch into BLX with the halfword bit in H
      if (rq.symbol_value[0])
         res.patched_word = {ARM_BLX_CODE[7:1], ARM_BLX_CODE[0] | offs[1], offs[25:2]};
      else
         res.patched_word = {rq.original_word[31:24], offs[25:2]};
      return res;
   endfunction

   function automatic patch_result_type patch_thumb_branch(input reloc_request_type rq,
                                                           input cfg_type cfg);
      patch_result_type res;
      logic [15:0]      hi, lo;
      logic [31:0]      offs;
      logic             s, j1, j2, link_bit;
      logic             thumb_target, to_plt, is_call, out_of_range;
      hi = rq.original_word[15:0];
      lo = rq.original_word[31:16];
      s = hi[10];
      thumb_target = rq.symbol_value[0];
      // window end is taken in 33 bits so it never wraps
      to_plt = {1'b0, rq.symbol_value} >= {1'b0, cfg.plt_base} &&
               {1'b0, rq.symbol_value} < {1'b0, cfg.plt_base} + {1'b0, cfg.plt_size};
      is_call = rq.command == CMD_THM_PC22;
      res.patched_word = rq.original_word;
      res.status = ST_OK;
      if (rq.weak_undefined)
         return res;
      if (!thumb_target && !to_plt && !is_call) begin
         res.status = ST_STUB;
         return res;
      end
      offs = {{7{s}}, s, ~(lo[13] ^ s), ~(lo[11] ^ s), hi[9:0], lo[10:0], 1'b0}
             + rq.symbol_value - rq.place_address;
      link_bit = 1'b1;
      if (!thumb_target && is_call) begin
         link_bit = 1'b0;
         offs = (offs + 32'd3) & ~32'd3;
      end
      out_of_range = !(offs[31:24] == 8'h00 || offs[31:24] == 8'hff);
      if ((!thumb_target || out_of_range) &&
          (thumb_target || rq.symbol_value[1] || (!is_call && !to_plt)))
         res.status = ST_BAD;
      s = offs[24];
      j1 = s ^ ~offs[23];
      j2 = s ^ ~offs[22];
      res.patched_word = {lo[15:14], j1, link_bit, j2, offs[11:1],
                          hi[15:11], s, offs[21:12]};
      return res;
   endfunction

   function automatic patch_result_type predict_patch(input reloc_request_type rq,
                                                      input cfg_type cfg);
      patch_result_type res;
      logic [31:0]      w, v;
      w = rq.original_word;
      res.patched_word = w;
      res.status = ST_OK;
      case (rq.command)
         CMD_PC24, CMD_CALL, CMD_JUMP24, CMD_PLT32: res = patch_arm_branch(rq, cfg);
         CMD_THM_PC22, CMD_THM_JUMP24: res = patch_thumb_branch(rq, cfg);
         CMD_MOVW_ABS_NC: res.patched_word = w + movw_field(rq.symbol_value[15:0]);
         CMD_MOVT_ABS: res.patched_word = w + movw_field(rq.symbol_value[31:16]);
         CMD_MOVW_PREL_NC, CMD_MOVT_PREL: begin
            v = rq.symbol_value + {{16{w[19]}}, w[19:16], w[11:0]} - rq.place_address;
            if (rq.command == CMD_MOVT_PREL)
               v = v >> 16;
            res.patched_word = (w & MOVW_KEEP_MASK) | movw_field(v[15:0]);
         end
         CMD_THM_MOVW_ABS_NC:
            res.patched_word = w + scatter_thumb_imm(rq.symbol_value[15:0]);
         CMD_THM_MOVT_ABS:
            res.patched_word = w | scatter_thumb_imm(rq.symbol_value[31:16]);
         CMD_PREL31: begin
            v = {w[30], w[30:0]} + rq.symbol_value - rq.place_address;
            if (v[31] != v[30])
               res.status = ST_BAD;
            res.patched_word = {w[31], v[30:0]};
         end
         CMD_ABS32: res.patched_word = w + rq.symbol_value;
         CMD_REL32: res.patched_word = w + rq.symbol_value - rq.place_address;
         CMD_GOTPC: res.patched_word = w + cfg.got_base - rq.place_address;
         CMD_GOTOFF: res.patched_word = w + rq.symbol_value - cfg.got_base;
         CMD_GOT32: res.patched_word = w + rq.got_entry_offset;
         CMD_GOT_PREL:
            res.patched_word = w + cfg.got_base + rq.got_entry_offset - rq.place_address;
         CMD_V4BX: begin
            if ((w & BX_MASK) == BX_PATTERN)
               res.patched_word = w ^ BX_WORD ^ MOV_PC_WORD;
         end
         CMD_GLOB_DAT: res.patched_word = rq.symbol_value;
         CMD_TLS_LE32:
            res.patched_word = w + rq.symbol_value - cfg.tls_base + TLS_TCB_SIZE;
         CMD_NONE: ;
         default: res.status = ST_UNHANDLED;
      endcase
      return res;
   endfunction

   // ---------------------------------------------------------------- checking

   always @(posedge clock) begin : check_results
      patch_result_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (pending_patches.size() == 0) begin
            $error("result with no request outstanding: word %h status %0d",
                   rsp_patched_word, rsp_status);
            failures++;
         end else begin
            want = pending_patches.pop_front();
            if (rsp_patched_word !== want.patched_word) begin
               $error("patched_word: expected %h, got %h", want.patched_word,
                      rsp_patched_word);
               failures++;
            end
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               failures++;
            end
            status_counts[rsp_status]++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && busy === 1'b0) || rsp_strobe === 1'b1)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("arm_relocation_patcher_core_test failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------- driving

   // start stays high after the beat so back-to-back requests need no toggle
   task automatic send_request(input reloc_request_type rq);
      req_command <= rq.command;
      req_original_word <= rq.original_word;
      req_place_address <= rq.place_address;
      req_symbol_value <= rq.symbol_value;
      req_got_entry_offset <= rq.got_entry_offset;
      req_weak_undefined <= rq.weak_undefined;
      start <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      pending_patches.push_back(predict_patch(rq, patcher_cfg));
      requests_sent++;
   endtask

   task automatic send_fields(input logic [CMD_W-1:0] cmd, input logic [31:0] w,
                              input logic [31:0] pa, input logic [31:0] sv,
                              input logic [31:0] go, input logic weak_flag);
      send_request('{cmd, w, pa, sv, go, weak_flag});
   endtask

   task automatic sender_gap();
      if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   task automatic wait_for_results();
      start <= 1'b0;
      while (pending_patches.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] index, input logic [31:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_write_data <= data;
      @(posedge clock);
      case (index)
         CSR_BLX_AVAILABLE: patcher_cfg.blx_available = data[0];
         CSR_GOT_BASE: patcher_cfg.got_base = data;
         CSR_PLT_BASE: patcher_cfg.plt_base = data;
         CSR_PLT_SIZE: patcher_cfg.plt_size = data;
         CSR_TLS_BASE: patcher_cfg.tls_base = data;
         default: ;
      endcase
   endtask

   task automatic set_patcher_config(input logic blx, input logic [31:0] got,
                                     input logic [31:0] plt_start, input logic [31:0] plt_bytes,
                                     input logic [31:0] tls);
      wait_for_results();
      csr_write(CSR_BLX_AVAILABLE, {31'b0, blx});
      csr_write(CSR_GOT_BASE, got);
      csr_write(CSR_PLT_BASE, plt_start);
      csr_write(CSR_PLT_SIZE, plt_bytes);
      csr_write(CSR_TLS_BASE, tls);
      csr_write_enable <= 1'b0;
      @(posedge clock);
      settings_applied++;
   endtask

   // ---------------------------------------------------------------- stimulus

   function automatic logic [31:0] any_word();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         2: return 32'h8000_0000;
         3: return 32'h7fff_ffff;
         default: return $urandom();
      endcase
   endfunction

   function automatic reloc_request_type random_request();
      reloc_request_type rq;
      int unsigned       pick;
      logic [31:0]       delta;
      pick = $urandom_range(0, 99);
      if (pick < 50)
         rq.command = CMD_W'($urandom_range(CMD_PC24, CMD_THM_JUMP24));
      else if (pick < 90)
         rq.command = CMD_W'($urandom_range(CMD_MOVW_ABS_NC, CMD_NONE));
      else
         rq.command = CMD_W'($urandom_range(CMD_NONE + 1, {CMD_W{1'b1}}));
      rq.original_word = any_word();
      rq.place_address = any_word();
      rq.got_entry_offset = any_word();
      rq.weak_undefined = $urandom_range(0, 7) == 0;
      // mostly targets near the place so branches land around their range limits
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
         if ($urandom_range(0, 1))
            delta = $urandom_range(0, 32'h01ff_ffff) - 32'h0100_0000;
         else
            delta = $urandom_range(0, 32'h03ff_ffff) - 32'h0200_0000;
         rq.symbol_value = rq.place_address + delta;
      end else if (pick < 8 && patcher_cfg.plt_size != 0) begin
         rq.symbol_value = patcher_cfg.plt_base + ($urandom() % patcher_cfg.plt_size);
         rq.symbol_value[0] = 1'b0;
      end else begin
         rq.symbol_value = any_word();
      end
      if (rq.command <= CMD_PLT32) begin
         case ($urandom_range(0, 2))
            0: rq.original_word[31:24] = ARM_BL_CODE;
            1: rq.original_word[31:24] = ARM_B_ALWAYS;
            default: ;
         endcase
         if ($urandom_range(0, 1))
            rq.original_word[23:0] = ARM_PC_ADDEND;
      end else if (rq.command == CMD_V4BX && $urandom_range(0, 1)) begin
         rq.original_word = (rq.original_word & ~BX_MASK) | BX_PATTERN;
      end
      return rq;
   endfunction

   task automatic test_arm_branches();
      send_fields(CMD_PC24, {ARM_BL_CODE, ARM_PC_ADDEND}, 32'h8000, 32'h9000, '0, 1'b0);
      // halfword-aligned Thumb target: H bit set
      send_fields(CMD_CALL, {ARM_BL_CODE, ARM_PC_ADDEND}, 32'h8000, 32'h9003, '0, 1'b0);
      send_fields(CMD_JUMP24, {ARM_B_ALWAYS, ARM_PC_ADDEND}, 32'h8000, 32'h9001, '0, 1'b0);
      send_fields(CMD_PLT32, {ARM_B_ALWAYS, 24'h0}, 32'h0, 32'h0200_0000, '0, 1'b0);
      send_fields(CMD_PC24, {ARM_B_ALWAYS, 24'h0}, 32'h0200_0000, 32'h0, '0, 1'b0);
   endtask

   task automatic test_thumb_branches();
      send_fields(CMD_THM_PC22, THM_BL_PAIR, 32'h1000, 32'h2001, '0, 1'b0);
      send_fields(CMD_THM_PC22, THM_BL_PAIR, 32'h1000, 32'h2000, '0, 1'b0);
      send_fields(CMD_THM_JUMP24, THM_BW_PAIR, 32'h1000, 32'h2000, '0, 1'b0);
      send_fields(CMD_THM_JUMP24, THM_BW_PAIR, 32'h1000, 32'h2001, '0, 1'b1);
      send_fields(CMD_THM_PC22, THM_BL_PAIR, 32'h1000, 32'h0100_1001, '0, 1'b0);
   endtask

   task automatic test_blx_unavailable();
      set_patcher_config(1'b0, 32'h0, 32'h1_0000, 32'h100, 32'h0);
      send_fields(CMD_CALL, {ARM_BL_CODE, ARM_PC_ADDEND}, 32'h8000, 32'h9001, '0, 1'b0);
      // B.W to ARM code inside the PLT needs no stub
      send_fields(CMD_THM_JUMP24, THM_BW_PAIR, 32'h1000, 32'h1_0010, '0, 1'b0);
   endtask

   task automatic test_data_relocations();
      logic [31:0] w;
      for (int k = CMD_MOVW_ABS_NC; k <= CMD_NONE; k++) begin
         w = (k % 2) ? '1 : '0;
         if (k == CMD_V4BX)
            w = BX_WORD | 32'he;
         if (k % 2)
            send_fields(CMD_W'(k), w, '0, '1, '1, 1'b1);
         else
            send_fields(CMD_W'(k), w, '1, 32'h8000_0001, '0, 1'b0);
      end
      send_fields({CMD_W{1'b1}}, '1, '1, '1, '1, 1'b1);
   endtask

   task automatic test_random_mix(input int n_items, input bit allow_gaps);
      for (int i = 0; i < n_items; i++) begin
         // alternate stretches of heavy, light and no idling
         if (i % 32 == 0)
            gap_odds = allow_gaps ? (1 << $urandom_range(0, 3)) - 1 : 0;
         sender_gap();
         send_request(random_request());
      end
   endtask

   initial begin
      patcher_cfg = '{1'b1, '0, '0, '0, '0};
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_arm_branches();
      test_thumb_branches();
      test_blx_unavailable();
      test_data_relocations();

      set_patcher_config(1'b1, '0, '0, '0, '0);
      test_random_mix(RANDOM_PHASE_ITEMS, 1'b1);
      set_patcher_config(1'b0, '1, '1, '1, '1);
      test_random_mix(RANDOM_PHASE_ITEMS, 1'b1);
      set_patcher_config(1'b1, $urandom(), $urandom(), $urandom_range(1, 32'hffff), $urandom());
      test_random_mix(RANDOM_PHASE_ITEMS, 1'b1);
      set_patcher_config(1'b0, $urandom(), '0, '1, $urandom());
      test_random_mix(RANDOM_PHASE_ITEMS, 1'b1);
      set_patcher_config(1'($urandom_range(0, 1)), $urandom(), $urandom(), $urandom(),
                         $urandom());
      test_random_mix(RANDOM_PHASE_ITEMS, 1'b1);
      set_patcher_config(1'b1, $urandom(), 32'hffff_0000, '1, $urandom());
      test_random_mix(RANDOM_PHASE_ITEMS, 1'b0);

      wait_for_results();
      repeat (8) @(posedge clock);

      $display("covered %0d relocation requests under %0d register settings",
               requests_sent, settings_applied);
      $display("results: %0d ok, %0d cannot relocate, %0d unhandled, %0d need a stub",
               status_counts[ST_OK], status_counts[ST_BAD], status_counts[ST_UNHANDLED],
               status_counts[ST_STUB]);
      if (failures == 0)
         $display("arm_relocation_patcher_core_test passed");
      else
         $display("arm_relocation_patcher_core_test failed");
      $finish;
   end

endmodule

// File: sim.f
rtl/arp_pkg.sv
rtl/arp_front.sv
rtl/arp_queue.sv
rtl/arp_back.sv
rtl/arm_relocation_patcher_core.sv
verif/arm_relocation_patcher_core_test.sv
